### hw/rtl/qdec_pkg.sv
// Shared types, command codes and the quadrature step decode for the dual decoder.
`timescale 1ns / 1ps

package qdec_pkg;

   // Command carried in the request tuser field.
   typedef enum logic [1:0] {
      CMD_PIN    = 2'd0,
      CMD_SAMPLE = 2'd1,
      CMD_CLEAR  = 2'd2,
      CMD_INIT   = 2'd3
   } cmd_type;

   // Direction of one decoded quadrature step.
   typedef enum logic [1:0] {
      DIR_NONE = 2'b00,
      DIR_UP   = 2'b01,
      DIR_DOWN = 2'b10
   } dir_type;

   // Per-channel control that the top level hands to each channel.
   typedef struct packed {
      logic       advance;
      cmd_type    cmd;
      logic       hit;
      logic [1:0] ab;
      logic       invert;
   } chan_ctrl_type;

   // Configuration register indexes.
   localparam logic CSR_LEFT_INVERT  = 1'b0;
   localparam logic CSR_RIGHT_INVERT = 1'b1;

   // Widths of the result fields and the packed channels.
   localparam int unsigned OUT_W      = 32;
   localparam int unsigned REQ_DATA_W = 8;
   localparam int unsigned RSP_DATA_W = 4 * OUT_W;

   // 4x decode: index is the previous AB pair over the current AB pair.
   // A state that does not change, or that jumps over two states, gives no step.
   function automatic dir_type step_dir(input logic [3:0] idx);
      dir_type dir;
      case (idx)
         4'b0010, 4'b0100, 4'b1011, 4'b1101: dir = DIR_UP;
         4'b0001, 4'b0111, 4'b1000, 4'b1110: dir = DIR_DOWN;
         default: dir = DIR_NONE;
      endcase
      return dir;
   endfunction

endpackage

### hw/rtl/qdec_chan.sv
// One decoder channel: previous pin levels, saturating position and sampled rate.
`timescale 1ns / 1ps

module qdec_chan #(
   parameter int unsigned COUNT_WIDTH = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  qdec_pkg::chan_ctrl_type              ctrl,
   output logic signed [qdec_pkg::OUT_W-1:0]    position,
   output logic signed [qdec_pkg::OUT_W-1:0]    rate
);

   localparam int unsigned EXT_W = COUNT_WIDTH + qdec_pkg::OUT_W;
   localparam logic signed [COUNT_WIDTH-1:0] CNT_MAX = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
   localparam logic signed [COUNT_WIDTH-1:0] CNT_MIN = {1'b1, {(COUNT_WIDTH-1){1'b0}}};
   localparam logic signed [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);

   logic [1:0]                    prev_ab_ff, prev_ab_in;
   logic signed [COUNT_WIDTH-1:0] count_ff, count_in;
   logic signed [COUNT_WIDTH-1:0] speed_ff, speed_in;
   logic signed [COUNT_WIDTH-1:0] last_ff, last_in;
   logic signed [COUNT_WIDTH:0]   diff;
   logic signed [COUNT_WIDTH-1:0] diff_sat;
   qdec_pkg::dir_type             dir;
   logic                          step_up, step_down;
   logic signed [EXT_W-1:0]       pos_ext, rate_ext;

   // Decode the step and apply the channel's direction setting.
   always_comb begin
      dir       = qdec_pkg::step_dir({prev_ab_ff, ctrl.ab});
      step_up   = ctrl.invert ? (dir == qdec_pkg::DIR_DOWN) : (dir == qdec_pkg::DIR_UP);
      step_down = ctrl.invert ? (dir == qdec_pkg::DIR_UP) : (dir == qdec_pkg::DIR_DOWN);
   end

   // Position minus last sample, one bit wider, clamped to the count range.
   always_comb begin
      diff = {count_ff[COUNT_WIDTH-1], count_ff} - {last_ff[COUNT_WIDTH-1], last_ff};
      if (diff[COUNT_WIDTH] != diff[COUNT_WIDTH-1]) begin
         diff_sat = diff[COUNT_WIDTH] ? CNT_MIN : CNT_MAX;
      end else begin
         diff_sat = diff[COUNT_WIDTH-1:0];
      end
   end

   // Next state for the item at hand.
   always_comb begin
      prev_ab_in = prev_ab_ff;
      count_in   = count_ff;
      speed_in   = speed_ff;
      last_in    = last_ff;
      case (ctrl.cmd)
         qdec_pkg::CMD_PIN: begin
            if (ctrl.hit) begin
               prev_ab_in = ctrl.ab;
               if (step_up && count_ff != CNT_MAX) begin
                  count_in = count_ff + CNT_ONE;
               end else if (step_down && count_ff != CNT_MIN) begin
                  count_in = count_ff - CNT_ONE;
               end
            end
         end
         qdec_pkg::CMD_SAMPLE: begin
            speed_in = diff_sat;
            last_in  = count_ff;
         end
         qdec_pkg::CMD_CLEAR: begin
            count_in = '0;
            speed_in = '0;
            last_in  = '0;
         end
         qdec_pkg::CMD_INIT: begin
            count_in   = '0;
            speed_in   = '0;
            last_in    = '0;
            prev_ab_in = ctrl.ab;
         end
         default: begin
            prev_ab_in = prev_ab_ff;
         end
      endcase
   end

   // Channel state moves only when an item is processed.
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ab_ff <= '0;
         count_ff   <= '0;
         speed_ff   <= '0;
         last_ff    <= '0;
      end else if (ctrl.advance) begin
         prev_ab_ff <= prev_ab_in;
         count_ff   <= count_in;
         speed_ff   <= speed_in;
         last_ff    <= last_in;
      end
   end

   // Results are the low bits of the sign-extended updated values.
   assign pos_ext  = EXT_W'(count_in);
   assign rate_ext = EXT_W'(speed_in);
   assign position = pos_ext[qdec_pkg::OUT_W-1:0];
   assign rate     = rate_ext[qdec_pkg::OUT_W-1:0];

endmodule

### hw/rtl/dual_quadrature_decoder_top.sv
// Top level of the two-channel 4x quadrature decoder.
// An accepted item waits in the input register until the result register is free or read.
// Throughput: one item per cycle unless stalled; the input register feeds both channels and the
// result register in a single pass, and a full, unread result register stalls req_tready.
// Reset: synchronous, active high; clears both valid flags, invert settings,
// previous pin levels, positions, rates and last samples.
`timescale 1ns / 1ps

module dual_quadrature_decoder_top #(
   parameter int unsigned COUNT_WIDTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   // Request channel.
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // tdata from bit 0: left_ab[1:0], right_ab[3:2], left_edge[4], right_edge[5], zero fill.
   input  logic [qdec_pkg::REQ_DATA_W-1:0]     req_tdata,
   // tuser: cmd[1:0].
   input  logic [1:0]                          req_tuser,
   // Result channel.
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // tdata from bit 0: left_position[31:0], right_position[63:32],
   // left_rate[95:64], right_rate[127:96].
   output logic [qdec_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // Configuration writes: index 0 left_invert, index 1 right_invert.
   input  logic                                csr_we,
   input  logic                                csr_index,
   input  logic                                csr_wdata
);

   localparam int unsigned W = qdec_pkg::OUT_W;

   logic                  item_valid_ff;
   qdec_pkg::cmd_type     cmd_ff;
   logic [1:0]            left_ab_ff, right_ab_ff;
   logic                  left_edge_ff, right_edge_ff;
   logic                  left_invert_ff, right_invert_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [qdec_pkg::RSP_DATA_W-1:0] rsp_data_ff;
   logic                  advance;
   logic                  req_accept;
   qdec_pkg::chan_ctrl_type left_ctrl, right_ctrl;
   logic signed [W-1:0]   left_position, right_position, left_rate, right_rate;

   // Handshake: the held item moves on when the result register is free or being read.
   assign advance    = item_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !item_valid_ff || advance;
   assign req_accept = req_tvalid && req_tready;

   // Invert settings.
   always_ff @(posedge clock) begin
      if (reset) begin
         left_invert_ff  <= 1'b0;
         right_invert_ff <= 1'b0;
      end else if (csr_we) begin
         if (csr_index == qdec_pkg::CSR_LEFT_INVERT) begin
            left_invert_ff <= csr_wdata;
         end else begin
            right_invert_ff <= csr_wdata;
         end
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (req_tready) begin
         item_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         cmd_ff        <= qdec_pkg::cmd_type'(req_tuser);
         left_ab_ff    <= req_tdata[1:0];
         right_ab_ff   <= req_tdata[3:2];
         left_edge_ff  <= req_tdata[4];
         right_edge_ff <= req_tdata[5];
      end
   end

   // Channel controls.
   always_comb begin
      left_ctrl.advance  = advance;
      left_ctrl.cmd      = cmd_ff;
      left_ctrl.hit      = left_edge_ff;
      left_ctrl.ab       = left_ab_ff;
      left_ctrl.invert   = left_invert_ff;
      right_ctrl.advance = advance;
      right_ctrl.cmd     = cmd_ff;
      right_ctrl.hit     = right_edge_ff;
      right_ctrl.ab      = right_ab_ff;
      right_ctrl.invert  = right_invert_ff;
   end

   qdec_chan #(.COUNT_WIDTH(COUNT_WIDTH)) u_left (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (left_ctrl),
      .position (left_position),
      .rate     (left_rate)
   );

   qdec_chan #(.COUNT_WIDTH(COUNT_WIDTH)) u_right (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (right_ctrl),
      .position (right_position),
      .rate     (right_rate)
   );

   // Result register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= {right_rate, left_rate, right_position, left_position};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

### hw/rtl/qdec_checker.sv
// Port-level checks on the dual quadrature decoder, bound to its top level.
`timescale 1ns / 1ps

module qdec_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [qdec_pkg::RSP_DATA_W-1:0]     rsp_tdata
);

   // A stalled result holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // Reset leaves no result pending.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result pending after reset");

   // The input side stalls only behind a full, stalled result register.
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("input stalled without output backpressure");

   // A new result appears only after an item was accepted.
   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready, 2))
      else $error("result without an accepted item");

endmodule

bind dual_quadrature_decoder_top qdec_checker u_qdec_checker (.*);

### tb/dual_quadrature_decoder_top_tb.sv
// Self-checking testbench for the dual quadrature decoder: directed and random items, random stalls.
`timescale 1ns / 1ps

module dual_quadrature_decoder_top_tb;

   localparam int unsigned CYCLE_LIMIT   = 300000;
   localparam int unsigned RANDOM_ITEMS  = 420;
   localparam int unsigned DRAIN_CYCLES  = 6;
   localparam int unsigned LONG_HOLD     = 400;
   localparam int unsigned HOLD_AT_COUNT = 300;
   localparam longint      POS_MAX       = 64'sd2147483647;
   localparam longint      POS_MIN       = -64'sd2147483648;

   // One pin item as the sender sees it.
   typedef struct {
      qdec_pkg::cmd_type cmd;
      logic [1:0] left_ab;
      logic [1:0] right_ab;
      logic       left_flag;
      logic       right_flag;
   } pin_item_type;

   // Counts and rates that one item reports.
   typedef struct {
      logic signed [31:0] left_position;
      logic signed [31:0] right_position;
      logic signed [31:0] left_rate;
      logic signed [31:0] right_rate;
   } counts_type;

   logic         clock       = 1'b0;
   logic         reset       = 1'b1;
   logic         req_tvalid  = 1'b0;
   logic         req_tready;
   logic [7:0]   req_tdata   = '0;
   logic [1:0]   req_tuser   = qdec_pkg::CMD_PIN;
   logic         rsp_tvalid;
   logic         rsp_tready  = 1'b0;
   logic [127:0] rsp_tdata;
   logic         csr_we      = 1'b0;
   logic         csr_index   = qdec_pkg::CSR_LEFT_INVERT;
   logic         csr_wdata   = 1'b0;

   // Stimulus and expectation stores.
   pin_item_type pin_items[$];
   counts_type   pending_counts[$];
   pin_item_type on_offer;
   logic      idling = 1'b1;
   int        mismatches = 0;
   int        cycle_count = 0;

   // Predictor state, channel 0 is left and channel 1 is right.
   logic [1:0] prev_levels[2];
   longint     position[2];
   longint     rate[2];
   longint     sampled[2];
   logic       invert[2];

   // Stimulus generator state: the physical pin levels and spin direction.
   logic [1:0] gen_levels[2];
   logic       gen_up[2];

   dual_quadrature_decoder_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Position of an AB pair along the forward rotation 00, 10, 11, 01.
   function automatic logic [1:0] phase_of(input logic [1:0] ab);
      case (ab)
         2'b00: return 2'd0;
         2'b10: return 2'd1;
         2'b11: return 2'd2;
         default: return 2'd3;
      endcase
   endfunction

   // Moves one channel by a single edge; a jump of two phases or none gives no step.
   function automatic void advance_channel(input int ch, input logic [1:0] cur);
      logic [1:0] delta;
      int         dir;
      delta = phase_of(cur) - phase_of(prev_levels[ch]);
      dir = (delta == 2'd1) ? 1 : (delta == 2'd3) ? -1 : 0;
      if (invert[ch])
         dir = -dir;
      if (dir > 0 && position[ch] < POS_MAX)
         position[ch] += 1;
      else if (dir < 0 && position[ch] > POS_MIN)
         position[ch] -= 1;
      prev_levels[ch] = cur;
   endfunction

   function automatic void clear_channels();
      for (int ch = 0; ch < 2; ch++) begin
         position[ch] = 0;
         rate[ch] = 0;
         sampled[ch] = 0;
      end
   endfunction

   // Applies one accepted item to the predictor and returns the counts it reports.
   function automatic counts_type decode_item(input pin_item_type it);
      counts_type res;
      longint     diff;
      case (it.cmd)
         qdec_pkg::CMD_PIN: begin
            if (it.left_flag)
               advance_channel(0, it.left_ab);
            if (it.right_flag)
               advance_channel(1, it.right_ab);
         end
         qdec_pkg::CMD_SAMPLE: begin
            for (int ch = 0; ch < 2; ch++) begin
               diff = position[ch] - sampled[ch];
               rate[ch] = (diff > POS_MAX) ? POS_MAX : (diff < POS_MIN) ? POS_MIN : diff;
               sampled[ch] = position[ch];
            end
         end
         qdec_pkg::CMD_CLEAR: begin
            clear_channels();
         end
         default: begin
            clear_channels();
            prev_levels[0] = it.left_ab;
            prev_levels[1] = it.right_ab;
         end
      endcase
      res.left_position  = position[0][31:0];
      res.right_position = position[1][31:0];
      res.left_rate      = rate[0][31:0];
      res.right_rate     = rate[1][31:0];
      return res;
   endfunction

   // Sender: offers queued items, with random gaps while idling is set, and predicts each accepted one.
   int send_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap = 0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid)
            pending_counts.push_back(decode_item(on_offer));
         if (send_gap > 0) begin
            send_gap--;
            req_tvalid <= 1'b0;
         end else if (pin_items.size() == 0) begin
            req_tvalid <= 1'b0;
         end else if (idling && $urandom_range(0, 7) == 0) begin
            send_gap = $urandom_range(0, 9);
            req_tvalid <= 1'b0;
         end else begin
            on_offer = pin_items.pop_front();
            req_tdata <= {2'b00, on_offer.right_flag, on_offer.left_flag,
                          on_offer.right_ab, on_offer.left_ab};
            req_tuser <= on_offer.cmd;
            req_tvalid <= 1'b1;
         end
      end
   end

   task automatic check_field(input string name, input logic signed [31:0] want,
                              input logic signed [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatches++;
      end
   endtask

   // Receiver: checks each result against the oldest prediction; stalls at random while idling is set.
   int stall_left = 0;
   int hold_left = 0;
   int results_seen = 0;
   logic hold_done = 1'b0;
   counts_type want;
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (pending_counts.size() == 0) begin
               $display("%0t: result with no item waiting, expected none, actual %h",
                        $time, rsp_tdata);
               mismatches++;
            end else begin
               want = pending_counts.pop_front();
               check_field("left_position", want.left_position, rsp_tdata[31:0]);
               check_field("right_position", want.right_position, rsp_tdata[63:32]);
               check_field("left_rate", want.left_rate, rsp_tdata[95:64]);
               check_field("right_rate", want.right_rate, rsp_tdata[127:96]);
            end
         end
         // One long hold-off lets the block fill up and push back on the sender.
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (!hold_done && results_seen >= HOLD_AT_COUNT) begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD - 1;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (idling && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 9);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   task automatic add_item(input qdec_pkg::cmd_type cmd, input logic [1:0] lab,
                           input logic [1:0] rab, input logic lflag, input logic rflag);
      pin_item_type it;
      it.cmd = cmd;
      it.left_ab = lab;
      it.right_ab = rab;
      it.left_flag = lflag;
      it.right_flag = rflag;
      pin_items.push_back(it);
   endtask

   function automatic logic [1:0] rotate(input logic [1:0] ab, input logic up);
      case (ab)
         2'b00: return up ? 2'b10 : 2'b01;
         2'b10: return up ? 2'b11 : 2'b00;
         2'b11: return up ? 2'b01 : 2'b10;
         default: return up ? 2'b00 : 2'b11;
      endcase
   endfunction

   // Mostly clean rotations with random direction changes, sprinkled with glitches,
   // missed edges, samples, clears and inits.
   task automatic add_random(input int count);
      int         pick;
      int         roll;
      logic       flag[2];
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 78) begin
            for (int ch = 0; ch < 2; ch++) begin
               if ($urandom_range(0, 19) == 0)
                  gen_up[ch] = ~gen_up[ch];
               roll = $urandom_range(0, 99);
               flag[ch] = 1'b0;
               if (roll < 60) begin
                  gen_levels[ch] = rotate(gen_levels[ch], gen_up[ch]);
                  flag[ch] = 1'b1;
               end else if (roll < 64) begin
                  gen_levels[ch] = gen_levels[ch] ^ 2'b11;
                  flag[ch] = 1'b1;
               end else if (roll < 68) begin
                  flag[ch] = 1'b1;
               end else if (roll < 72) begin
                  gen_levels[ch] = rotate(gen_levels[ch], gen_up[ch]);
               end
            end
            add_item(qdec_pkg::CMD_PIN, gen_levels[0], gen_levels[1], flag[0], flag[1]);
         end else if (pick < 88) begin
            add_item(qdec_pkg::CMD_SAMPLE, 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         end else if (pick < 94) begin
            add_item(qdec_pkg::CMD_CLEAR, 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         end else begin
            if ($urandom_range(0, 3) == 0) begin
               gen_levels[0] = 2'($urandom_range(0, 3));
               gen_levels[1] = 2'($urandom_range(0, 3));
            end
            add_item(qdec_pkg::CMD_INIT, gen_levels[0], gen_levels[1],
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         end
      end
   endtask

   // Waits until every item went through and every result came back.
   task automatic wait_drained();
      @(posedge clock);
      while (pin_items.size() > 0 || req_tvalid || pending_counts.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_invert(input logic idx, input logic value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      invert[idx] = value;
   endtask

   task automatic run_phase(input logic left_inv, input logic right_inv, input logic gaps);
      write_invert(qdec_pkg::CSR_LEFT_INVERT, left_inv);
      write_invert(qdec_pkg::CSR_RIGHT_INVERT, right_inv);
      idling <= gaps;
      add_random(RANDOM_ITEMS);
      wait_drained();
   endtask

   // Test sequence.
   initial begin
      for (int ch = 0; ch < 2; ch++) begin
         prev_levels[ch] = 2'b00;
         invert[ch] = 1'b0;
         gen_levels[ch] = 2'b00;
         gen_up[ch] = ch[0];
      end
      clear_channels();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed items under the reset settings.
      add_item(qdec_pkg::CMD_INIT,   2'b11, 2'b00, 1'b1, 1'b1);  // edge flags ignored, pins captured
      add_item(qdec_pkg::CMD_PIN,    2'b01, 2'b10, 1'b1, 1'b1);  // both forward
      add_item(qdec_pkg::CMD_PIN,    2'b00, 2'b11, 1'b1, 1'b1);  // both forward
      add_item(qdec_pkg::CMD_PIN,    2'b00, 2'b11, 1'b1, 1'b1);  // flagged with no change
      add_item(qdec_pkg::CMD_PIN,    2'b11, 2'b00, 1'b1, 1'b1);  // double jumps still move levels
      add_item(qdec_pkg::CMD_PIN,    2'b10, 2'b01, 1'b0, 1'b0);  // no flags, nothing happens
      add_item(qdec_pkg::CMD_SAMPLE, 2'b01, 2'b10, 1'b1, 1'b1);  // pins ignored on a sample
      add_item(qdec_pkg::CMD_PIN,    2'b10, 2'b01, 1'b1, 1'b0);  // left backward only
      add_item(qdec_pkg::CMD_PIN,    2'b00, 2'b01, 1'b1, 1'b1);  // both backward
      add_item(qdec_pkg::CMD_SAMPLE, 2'b00, 2'b00, 1'b0, 1'b0);
      add_item(qdec_pkg::CMD_CLEAR,  2'b11, 2'b11, 1'b1, 1'b1);  // previous levels survive a clear
      add_item(qdec_pkg::CMD_PIN,    2'b01, 2'b11, 1'b1, 1'b1);
      add_item(qdec_pkg::CMD_SAMPLE, 2'b11, 2'b11, 1'b1, 1'b1);
      add_item(qdec_pkg::CMD_INIT,   2'b00, 2'b00, 1'b0, 1'b0);
      add_item(qdec_pkg::CMD_PIN,    2'b10, 2'b10, 1'b1, 1'b1);
      add_item(qdec_pkg::CMD_PIN,    2'b11, 2'b11, 1'b1, 1'b1);
      add_item(qdec_pkg::CMD_PIN,    2'b01, 2'b01, 1'b1, 1'b1);
      add_item(qdec_pkg::CMD_SAMPLE, 2'b10, 2'b01, 1'b0, 1'b1);
      add_item(qdec_pkg::CMD_PIN,    2'b11, 2'b00, 1'b1, 1'b1);
      add_item(qdec_pkg::CMD_SAMPLE, 2'b00, 2'b00, 1'b0, 1'b0);
      add_item(qdec_pkg::CMD_CLEAR,  2'b00, 2'b00, 1'b0, 1'b0);
      wait_drained();

      // Random phases across every invert setting; the second and the last run without gaps.
      run_phase(1'b1, 1'b0, 1'b1);
      run_phase(1'b0, 1'b1, 1'b0);
      run_phase(1'b1, 1'b1, 1'b1);
      run_phase(1'b0, 1'b0, 1'b0);

      if (mismatches == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
